FILE: sv/ssae_pkg.sv
package ssae_pkg;

	localparam int PATTERN_SLOTS_DEF = 8;
	localparam int PLAYER_SLOTS_DEF  = 256;

	typedef enum logic [2:0] {
		OP_REGISTER = 3'd0,
		OP_CREATE   = 3'd1,
		OP_DESTROY  = 3'd2,
		OP_TICK     = 3'd3,
		OP_DRAW     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_INACTIVE = 2'd2,
		ST_ZERO_ROW = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_TICK_RD,
		S_TICK_PLY,
		S_TICK_PAT,
		S_TICK_WR,
		S_DRAW_RD,
		S_DRAW_PAT,
		S_DRAW_DIV,
		S_DRAW_MUL,
		S_DRAW_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  slot_index;
		logic [15:0] texture_id;
		logic [7:0]  frame_count;
		logic [7:0]  frames_per_row;
		logic [31:0] frame_period;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] cell_width;
		logic [15:0] cell_height;
		logic        loop_mode;
		logic [23:0] elapsed_time;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  granted_index;
		logic [15:0] sheet_texture;
		logic [15:0] source_x;
		logic [15:0] source_y;
		logic [15:0] source_width;
		logic [15:0] source_height;
		logic        finished_flag;
	} out_word_t;

	// pattern record: texture, count, per_row, period, x0, y0, w, h, looping
	typedef struct packed {
		logic [15:0] texture;
		logic [7:0]  count;
		logic [7:0]  per_row;
		logic [31:0] period;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] w;
		logic [15:0] h;
		logic        looping;
	} pattern_t;

	localparam int PATTERN_W = $bits(pattern_t);

	// player record: bound pattern slot, frame, time, done
	typedef struct packed {
		logic [3:0]  pat_sel;
		logic [7:0]  frame;
		logic [31:0] ptime;
		logic        done;
	} player_t;

	localparam int PLAYER_W = $bits(player_t);

endpackage

FILE: sv/sprite_sheet_animation_engine.sv
// channel | signals                  | handshake
// in      | in_word (in_word_t)      | start & !busy
// out     | result (out_word_t)      | done, one cycle, cannot stall
//
// Register, destroy, unknown ops and a draw of an inactive player strobe the
// result in the cycle after accept. Create scans player slots one a cycle and
// strobes at the first free one, or with status full after the last. Draw
// divides one quotient bit a cycle; zero frames per row stops it at the divide.
// Tick visits every slot, an active one through read, player, pattern and
// write-back states. Both tables live in synchronous RAMs; a player record is
// read, updated and written back. Reset clears the pattern valid and player
// active bits at once. busy stays high from accept until the result strobe.
module sprite_sheet_animation_engine #(
	parameter int PATTERN_SLOTS = ssae_pkg::PATTERN_SLOTS_DEF,
	parameter int PLAYER_SLOTS  = ssae_pkg::PLAYER_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ssae_pkg::in_word_t in_word,
	output logic               busy,
	output logic               done,
	output ssae_pkg::out_word_t result
);

	localparam int PAW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
	localparam int PLW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
	localparam int PCW = $clog2(PLAYER_SLOTS + 1);

	ssae_pkg::state_t state_q, state_d;
	ssae_pkg::in_word_t req_q;
	ssae_pkg::out_word_t res_q;
	ssae_pkg::out_word_t res_init;

	logic [PATTERN_SLOTS-1:0] pvalid_q;
	logic [PLAYER_SLOTS-1:0]  active_q;

	logic [PCW-1:0] cnt_q;
	logic [PLW-1:0] cur_q;

	logic               pat_we;
	logic [PAW-1:0]     pat_waddr, pat_raddr;
	ssae_pkg::pattern_t pat_wdata, pat_rdata;
	logic               ply_we;
	logic [PLW-1:0]     ply_waddr, ply_raddr;
	ssae_pkg::player_t  ply_wdata, ply_rdata;

	ssae_pkg::player_t  ply_q;
	ssae_pkg::pattern_t pat_q;

	logic [7:0]  quo_q, rem_q;
	logic [3:0]  bit_q;
	logic [31:0] mx_q, my_q;

	ssae_pkg::pattern_t new_pat;
	logic [PAW-1:0]     free_pat;
	logic               pat_full;
	logic               idx_in_range;
	logic [PLW-1:0]     idx_sel;
	logic [3:0]         new_sel;
	ssae_pkg::player_t  upd;
	logic [8:0]         fnext;
	logic [31:0]        tsub;
	logic [32:0]        tsum;
	logic [8:0]         rtry;
	logic [16:0]        sx, sy;

	// pattern slot of a create: index modulo PATTERN_SLOTS
	function automatic logic [3:0] pat_of(logic [7:0] v);
		logic [11:0] r;
		r = {4'd0, v};
		for (int k = 7; k >= 0; k--) begin
			if (r >= 12'(PATTERN_SLOTS << k))
				r = r - 12'(PATTERN_SLOTS << k);
		end
		return r[3:0];
	endfunction

	ssae_ram #(.WIDTH(ssae_pkg::PATTERN_W), .DEPTH(PATTERN_SLOTS)) u_pat_ram (
		.clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
		.raddr(pat_raddr), .rdata(pat_rdata)
	);

	ssae_ram #(.WIDTH(ssae_pkg::PLAYER_W), .DEPTH(PLAYER_SLOTS)) u_ply_ram (
		.clk(clk), .we(ply_we), .waddr(ply_waddr), .wdata(ply_wdata),
		.raddr(ply_raddr), .rdata(ply_rdata)
	);

	always_comb begin
		free_pat = '0;
		pat_full = 1'b1;
		for (int i = PATTERN_SLOTS - 1; i >= 0; i--) begin
			if (!pvalid_q[i]) begin
				free_pat = PAW'(i);
				pat_full = 1'b0;
			end
		end
	end

	assign idx_in_range = {24'd0, in_word.slot_index} < PLAYER_SLOTS;
	assign idx_sel      = PLW'(in_word.slot_index);
	assign new_sel      = pat_of(req_q.slot_index);

	always_comb begin
		new_pat.texture = in_word.texture_id;
		new_pat.count   = in_word.frame_count;
		new_pat.per_row = in_word.frames_per_row;
		new_pat.period  = in_word.frame_period;
		new_pat.x0      = in_word.start_x;
		new_pat.y0      = in_word.start_y;
		new_pat.w       = in_word.cell_width;
		new_pat.h       = in_word.cell_height;
		new_pat.looping = in_word.loop_mode;
	end

	always_comb begin
		res_init = '0;
		priority case (in_word.operation)
			ssae_pkg::OP_REGISTER: begin
				res_init.status = pat_full ? ssae_pkg::ST_FULL : ssae_pkg::ST_OK;
				res_init.granted_index = pat_full ? 8'd0 : 8'(free_pat);
			end
			ssae_pkg::OP_DESTROY:
				res_init.status = idx_in_range ? ssae_pkg::ST_OK
					: ssae_pkg::ST_INACTIVE;
			ssae_pkg::OP_DRAW:
				if (!(idx_in_range && active_q[idx_sel]))
					res_init.status = ssae_pkg::ST_INACTIVE;
			default: ;
		endcase
	end

	// tick update of one player record
	always_comb begin
		upd   = ply_q;
		fnext = {1'b0, ply_q.frame} + 9'd1;
		tsub  = ply_q.ptime;
		if (ply_q.ptime >= pat_q.period) begin
			if (fnext >= {1'b0, pat_q.count}) begin
				if (pat_q.looping || pat_q.count == 8'd0)
					upd.frame = 8'd0;
				else
					upd.frame = pat_q.count - 8'd1;
				upd.done = 1'b1;
			end else begin
				upd.frame = fnext[7:0];
			end
			tsub = ply_q.ptime - pat_q.period;
		end
		tsum = {1'b0, tsub} + {9'd0, req_q.elapsed_time};
		upd.ptime = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
	end

	assign rtry = {rem_q, quo_q[7]} - {1'b0, pat_q.per_row};
	assign sx   = {1'b0, pat_q.x0} + {1'b0, mx_q[15:0]};
	assign sy   = {1'b0, pat_q.y0} + {1'b0, my_q[15:0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssae_pkg::S_IDLE: begin
				if (start) begin
					priority case (in_word.operation)
						ssae_pkg::OP_CREATE: state_d = ssae_pkg::S_SCAN;
						ssae_pkg::OP_TICK:   state_d = ssae_pkg::S_TICK_RD;
						ssae_pkg::OP_DRAW:
							state_d = (idx_in_range && active_q[idx_sel])
								? ssae_pkg::S_DRAW_RD : ssae_pkg::S_DONE;
						default:             state_d = ssae_pkg::S_DONE;
					endcase
				end
			end
			ssae_pkg::S_SCAN: begin
				if (cnt_q == PCW'(PLAYER_SLOTS) || !active_q[cur_q])
					state_d = ssae_pkg::S_DONE;
			end
			ssae_pkg::S_TICK_RD: begin
				if (cnt_q == PCW'(PLAYER_SLOTS))
					state_d = ssae_pkg::S_DONE;
				else if (active_q[cur_q])
					state_d = ssae_pkg::S_TICK_PLY;
			end
			ssae_pkg::S_TICK_PLY: state_d = ssae_pkg::S_TICK_PAT;
			ssae_pkg::S_TICK_PAT: state_d = ssae_pkg::S_TICK_WR;
			ssae_pkg::S_TICK_WR:  state_d = ssae_pkg::S_TICK_RD;
			ssae_pkg::S_DRAW_RD:  state_d = ssae_pkg::S_DRAW_PAT;
			ssae_pkg::S_DRAW_PAT: state_d = ssae_pkg::S_DRAW_DIV;
			ssae_pkg::S_DRAW_DIV: begin
				if (pat_q.per_row == 8'd0)
					state_d = ssae_pkg::S_DONE;
				else if (bit_q == 4'd7)
					state_d = ssae_pkg::S_DRAW_MUL;
			end
			ssae_pkg::S_DRAW_MUL: state_d = ssae_pkg::S_DRAW_OUT;
			ssae_pkg::S_DRAW_OUT: state_d = ssae_pkg::S_DONE;
			ssae_pkg::S_DONE:     state_d = ssae_pkg::S_IDLE;
			default:              state_d = ssae_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		pat_we    = 1'b0;
		pat_waddr = free_pat;
		pat_wdata = new_pat;
		pat_raddr = PAW'(ply_rdata.pat_sel);
		ply_we    = 1'b0;
		ply_waddr = cur_q;
		ply_wdata = upd;
		ply_raddr = cur_q;
		unique case (state_q)
			ssae_pkg::S_IDLE: begin
				pat_we = start && in_word.operation == ssae_pkg::OP_REGISTER
					&& !pat_full;
				ply_raddr = idx_sel;
			end
			ssae_pkg::S_SCAN: begin
				ply_we = cnt_q != PCW'(PLAYER_SLOTS) && !active_q[cur_q];
				ply_wdata = '0;
				ply_wdata.pat_sel = new_sel;
			end
			ssae_pkg::S_TICK_WR: ply_we = 1'b1;
			default: ;
		endcase
	end

	assign busy   = state_q != ssae_pkg::S_IDLE;
	assign done   = state_q == ssae_pkg::S_DONE;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ssae_pkg::S_IDLE;
			pvalid_q <= '0;
			active_q <= '0;
			cnt_q    <= '0;
			cur_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ssae_pkg::S_IDLE: begin
					cnt_q <= '0;
					cur_q <= '0;
					if (start) begin
						if (in_word.operation == ssae_pkg::OP_REGISTER && !pat_full)
							pvalid_q[free_pat] <= 1'b1;
						if (in_word.operation == ssae_pkg::OP_DESTROY && idx_in_range)
							active_q[idx_sel] <= 1'b0;
						if (in_word.operation == ssae_pkg::OP_DRAW)
							cur_q <= idx_sel;
					end
				end
				ssae_pkg::S_SCAN: begin
					if (cnt_q != PCW'(PLAYER_SLOTS)) begin
						if (!active_q[cur_q])
							active_q[cur_q] <= 1'b1;
						else begin
							cnt_q <= cnt_q + 1'b1;
							cur_q <= cur_q + 1'b1;
						end
					end
				end
				ssae_pkg::S_TICK_RD: begin
					if (cnt_q != PCW'(PLAYER_SLOTS) && !active_q[cur_q]) begin
						cnt_q <= cnt_q + 1'b1;
						cur_q <= cur_q + 1'b1;
					end
				end
				ssae_pkg::S_TICK_WR: begin
					cnt_q <= cnt_q + 1'b1;
					cur_q <= cur_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ssae_pkg::S_IDLE: begin
				if (start) begin
					req_q <= in_word;
					res_q <= res_init;
				end
			end
			ssae_pkg::S_SCAN: begin
				if (cnt_q == PCW'(PLAYER_SLOTS))
					res_q.status <= ssae_pkg::ST_FULL;
				else if (!active_q[cur_q])
					res_q.granted_index <= 8'(cur_q);
			end
			ssae_pkg::S_TICK_PLY: ply_q <= ply_rdata;
			ssae_pkg::S_TICK_PAT: pat_q <= pat_rdata;
			ssae_pkg::S_DRAW_RD: ply_q <= ply_rdata;
			ssae_pkg::S_DRAW_PAT: begin
				pat_q <= pat_rdata;
				quo_q <= ply_q.frame;
				rem_q <= '0;
				bit_q <= '0;
			end
			ssae_pkg::S_DRAW_DIV: begin
				res_q.sheet_texture <= pat_q.texture;
				res_q.source_width  <= pat_q.w;
				res_q.source_height <= pat_q.h;
				res_q.finished_flag <= ply_q.done;
				if (pat_q.per_row == 8'd0)
					res_q.status <= ssae_pkg::ST_ZERO_ROW;
				else begin
					bit_q <= bit_q + 4'd1;
					if (!rtry[8]) begin
						rem_q <= rtry[7:0];
						quo_q <= {quo_q[6:0], 1'b1};
					end else begin
						rem_q <= {rem_q[6:0], quo_q[7]};
						quo_q <= {quo_q[6:0], 1'b0};
					end
				end
			end
			ssae_pkg::S_DRAW_MUL: begin
				mx_q <= {16'd0, pat_q.w} * {24'd0, rem_q};
				my_q <= {16'd0, pat_q.h} * {24'd0, quo_q};
			end
			ssae_pkg::S_DRAW_OUT: begin
				res_q.source_x <= (sx[16] || mx_q[31:16] != 16'd0) ? 16'hFFFF : sx[15:0];
				res_q.source_y <= (sy[16] || my_q[31:16] != 16'd0) ? 16'hFFFF : sy[15:0];
			end
			default: ;
		endcase
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result strobe");

	a_scan_writes_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssae_pkg::S_SCAN && ply_we) |-> !active_q[ply_waddr])
		else $error("create overwrote an active player");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

endmodule

FILE: sv/ssae_ram.sv
module ssae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/sv/sprite_sheet_animation_engine_test.sv
module sprite_sheet_animation_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PAT = ssae_pkg::PATTERN_SLOTS_DEF;
	localparam int N_PLY = ssae_pkg::PLAYER_SLOTS_DEF;
	localparam longint CYCLE_LIMIT = 64'd20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ssae_pkg::in_word_t in_word = '0;
	logic busy;
	logic done;
	ssae_pkg::out_word_t result;

	sprite_sheet_animation_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	bit                 pat_used[N_PAT];
	ssae_pkg::pattern_t pat_rec[N_PAT];
	bit                 ply_on[N_PLY];
	logic [2:0]         ply_pat[N_PLY];
	logic [7:0]         ply_frame[N_PLY];
	logic [31:0]        ply_time[N_PLY];
	bit                 ply_done[N_PLY];

	ssae_pkg::out_word_t expected_words[$];
	int        errors = 0;
	longint    cycles = 0;
	int        send_idle = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] sat16(logic [63:0] v);
		return v > 64'hFFFF ? 16'hFFFF : v[15:0];
	endfunction

	function automatic ssae_pkg::out_word_t animate(ssae_pkg::in_word_t w);
		ssae_pkg::out_word_t r = '0;
		int i;
		ssae_pkg::pattern_t p;
		logic [8:0] f;
		logic [32:0] s;
		logic [7:0] fr;
		case (w.operation)
			ssae_pkg::OP_REGISTER: begin
				for (i = 0; i < N_PAT; i++) if (!pat_used[i]) break;
				if (i == N_PAT) r.status = ssae_pkg::ST_FULL;
				else begin
					pat_used[i] = 1;
					pat_rec[i] = '{w.texture_id, w.frame_count, w.frames_per_row,
						w.frame_period, w.start_x, w.start_y, w.cell_width,
						w.cell_height, w.loop_mode};
					r.granted_index = 8'(i);
				end
			end
			ssae_pkg::OP_CREATE: begin
				for (i = 0; i < N_PLY; i++) if (!ply_on[i]) break;
				if (i == N_PLY) r.status = ssae_pkg::ST_FULL;
				else begin
					ply_on[i] = 1; ply_pat[i] = 3'(w.slot_index % N_PAT);
					ply_frame[i] = 0; ply_time[i] = 0; ply_done[i] = 0;
					r.granted_index = 8'(i);
				end
			end
			ssae_pkg::OP_DESTROY: ply_on[w.slot_index] = 0;
			ssae_pkg::OP_TICK: begin
				for (i = 0; i < N_PLY; i++) begin
					if (!ply_on[i]) continue;
					p = pat_rec[ply_pat[i]];
					if (ply_time[i] >= p.period) begin
						f = ply_frame[i] + 9'd1;
						if (f >= p.count) begin
							f = (p.looping || p.count == 0) ? 9'd0
								: {1'b0, p.count - 8'd1};
							ply_done[i] = 1;
						end
						ply_frame[i] = f[7:0];
						ply_time[i] -= p.period;
					end
					s = ply_time[i] + w.elapsed_time;
					ply_time[i] = s[32] ? 32'hFFFF_FFFF : s[31:0];
				end
			end
			ssae_pkg::OP_DRAW: begin
				if (!ply_on[w.slot_index]) r.status = ssae_pkg::ST_INACTIVE;
				else begin
					i = w.slot_index;
					p = pat_rec[ply_pat[i]];
					r.sheet_texture = p.texture;
					r.source_width = p.w;
					r.source_height = p.h;
					r.finished_flag = ply_done[i];
					fr = ply_frame[i];
					if (p.per_row == 0) r.status = ssae_pkg::ST_ZERO_ROW;
					else begin
						r.source_x = sat16(64'(p.x0) + 64'(p.w) * (fr % p.per_row));
						r.source_y = sat16(64'(p.y0) + 64'(p.h) * (fr / p.per_row));
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		ssae_pkg::out_word_t e;
		if (done) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status); errors++; end
				if (result.granted_index !== e.granted_index) begin
					$error("granted_index exp %0d got %0d", e.granted_index,
						result.granted_index); errors++; end
				if (result.sheet_texture !== e.sheet_texture) begin
					$error("sheet_texture exp %0d got %0d", e.sheet_texture,
						result.sheet_texture); errors++; end
				if (result.source_x !== e.source_x) begin
					$error("source_x exp %0d got %0d", e.source_x, result.source_x);
					errors++; end
				if (result.source_y !== e.source_y) begin
					$error("source_y exp %0d got %0d", e.source_y, result.source_y);
					errors++; end
				if (result.source_width !== e.source_width) begin
					$error("source_width exp %0d got %0d", e.source_width,
						result.source_width); errors++; end
				if (result.source_height !== e.source_height) begin
					$error("source_height exp %0d got %0d", e.source_height,
						result.source_height); errors++; end
				if (result.finished_flag !== e.finished_flag) begin
					$error("finished_flag exp %0d got %0d", e.finished_flag,
						result.finished_flag); errors++; end
			end
		end
	end

	// start is left high after an accept; drop it before any idle cycles
	task automatic send_word(ssae_pkg::in_word_t w);
		int gap;
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		expected_words.push_back(animate(w));
	endtask

	function automatic ssae_pkg::in_word_t rand_word();
		logic [191:0] b;
		b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return b[$bits(ssae_pkg::in_word_t)-1:0];
	endfunction

	task automatic send_op(ssae_pkg::op_t op, logic [7:0] idx);
		ssae_pkg::in_word_t w = rand_word();
		w.operation = op; w.slot_index = idx;
		send_word(w);
	endtask

	task automatic send_pattern(ssae_pkg::in_word_t w);
		w.operation = ssae_pkg::OP_REGISTER;
		if (w.frame_count == 0) w.frame_count = 1;
		send_word(w);
	endtask

	function automatic logic [7:0] used_pattern();
		int k;
		for (int t = 0; t < 50; t++) begin
			k = $urandom_range(N_PAT - 1);
			if (pat_used[k]) return 8'(k + N_PAT * $urandom_range(31));
		end
		for (k = 0; k < N_PAT; k++) if (pat_used[k]) return 8'(k);
		return 0;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		ssae_pkg::in_word_t w;
		w = '1; w.frame_count = 8'd255; w.frames_per_row = 8'd255;
		w.frame_period = 0; send_pattern(w);
		w = '0; w.frame_count = 8'd5; w.frames_per_row = 0; w.frame_period = 3;
		w.texture_id = 16'h1234; w.cell_width = 7; send_pattern(w);
		w = '0; w.frame_count = 8'd4; w.frames_per_row = 2; w.frame_period = 10;
		w.loop_mode = 1; w.start_x = 100; w.cell_width = 16; w.cell_height = 9;
		send_pattern(w);
		send_op(ssae_pkg::OP_CREATE, 8'd0);
		send_op(ssae_pkg::OP_CREATE, 8'd9);
		send_op(ssae_pkg::OP_CREATE, 8'd2);
		send_op(ssae_pkg::OP_DRAW, 8'd0);
		send_op(ssae_pkg::OP_DRAW, 8'd1);
		send_op(ssae_pkg::OP_DRAW, 8'd200);
		w = '0; w.operation = ssae_pkg::OP_TICK; w.elapsed_time = 24'hFFFFFF;
		send_word(w);
		repeat (3) send_word(w);
		w.elapsed_time = 0; send_word(w);
		send_op(ssae_pkg::OP_DRAW, 8'd0);
		send_op(ssae_pkg::OP_DRAW, 8'd2);
		send_op(ssae_pkg::OP_DESTROY, 8'd1);
		send_op(ssae_pkg::OP_DESTROY, 8'd1);
		send_op(ssae_pkg::OP_DRAW, 8'd1);
		w = rand_word(); w.operation = 3'd5; send_word(w);
		w.operation = 3'd7; send_word(w);
		repeat (6) send_pattern(rand_word());
		drain();
	endtask

	task automatic test_fill_players();
		for (int i = 0; i < N_PLY + 2; i++) send_op(ssae_pkg::OP_CREATE, used_pattern());
		for (int i = 0; i < N_PLY; i += 3) send_op(ssae_pkg::OP_DESTROY, 8'(i));
		drain();
	endtask

	task automatic test_random(int count);
		ssae_pkg::in_word_t w;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			w = rand_word();
			if (r < 25) begin
				w.operation = ssae_pkg::OP_TICK;
				if ($urandom_range(3) != 0) w.elapsed_time = 24'($urandom_range(40));
				send_word(w);
			end else if (r < 55) begin
				send_op(ssae_pkg::OP_DRAW, $urandom_range(3) == 0 ? w.slot_index :
					8'($urandom_range(N_PLY - 1)));
			end else if (r < 72) send_op(ssae_pkg::OP_CREATE, used_pattern());
			else if (r < 88) send_op(ssae_pkg::OP_DESTROY, w.slot_index);
			else if (r < 93) send_pattern(w);
			else begin
				w.operation = 3'($urandom_range(5, 7)); send_word(w);
			end
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 0;
		test_directed();
		test_fill_players();
		test_random(270);
		send_idle = 69;
		test_random(270);
		send_idle = 32;
		test_random(270);
		send_idle = 0;
		test_random(270);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

FILE: sim.f
sv/ssae_pkg.sv
sv/ssae_ram.sv
sv/sprite_sheet_animation_engine.sv
tb/sv/sprite_sheet_animation_engine_test.sv
